// ===== hw/rtl/bid_pkg.sv =====
package bid_pkg;

    localparam int INSTR_W   = 41;
    localparam int ADDR_W    = 64;
    localparam int S_DATA_W  = 112;
    localparam int M_DATA_W  = 96;

    typedef enum logic [3:0] {
        KIND_COND  = 4'd0,
        KIND_CALL  = 4'd1,
        KIND_RET   = 4'd2,
        KIND_RFI   = 4'd3,
        KIND_IA    = 4'd4,
        KIND_CLOOP = 4'd5,
        KIND_CTOP  = 4'd6,
        KIND_CEXIT = 4'd7,
        KIND_WTOP  = 4'd8,
        KIND_WEXIT = 4'd9
    } bid_kind_e;

    localparam logic [3:0] MAJOR_SYS   = 4'd0;
    localparam logic [3:0] MAJOR_IND   = 4'd1;
    localparam logic [3:0] MAJOR_REL   = 4'd4;
    localparam logic [3:0] MAJOR_CALL  = 4'd5;

    localparam logic [5:0] X6_RFI      = 6'h08;
    localparam logic [5:0] X6_IND_COND = 6'h20;
    localparam logic [5:0] X6_RET_SPEC = 6'h21;
    localparam logic [1:0] X6_LOOP_GRP = 2'b10;

    localparam logic [2:0] BTYPE_0 = 3'd0;
    localparam logic [2:0] BTYPE_1 = 3'd1;
    localparam logic [2:0] BTYPE_2 = 3'd2;
    localparam logic [2:0] BTYPE_3 = 3'd3;
    localparam logic [2:0] BTYPE_4 = 3'd4;
    localparam logic [2:0] BTYPE_5 = 3'd5;
    localparam logic [2:0] BTYPE_6 = 3'd6;
    localparam logic [2:0] BTYPE_7 = 3'd7;

    typedef struct packed {
        logic              decode_ok;
        bid_kind_e         branch_kind;
        logic [5:0]        qualifying_predicate;
        logic [2:0]        dest_branch_reg;
        logic [2:0]        source_branch_reg;
        logic [1:0]        whether_hint;
        logic              dealloc_hint;
        logic              prefetch_hint;
        logic [7:0]        combined_opcode;
        logic              is_indirect;
        logic              target_valid;
        logic [ADDR_W-1:0] target_address;
    } bid_result_t;

    function automatic bid_kind_e register_kind(input logic [5:0] x6);
        bid_kind_e k;
        case (x6[4:0])
            5'h00, 5'h01: k = KIND_CALL;
            5'h04:        k = KIND_RET;
            5'h05:        k = KIND_IA;
            default:      k = KIND_COND;
        endcase
        return k;
    endfunction

    function automatic bid_kind_e relative_kind(input logic [2:0] btype,
                                                input logic [5:0] x6);
        bid_kind_e k;
        k = KIND_COND;
        if (btype == BTYPE_0 || btype == BTYPE_4) begin
            k = KIND_COND;
        end else if (btype == BTYPE_1 || btype == BTYPE_5) begin
            k = KIND_CALL;
        end else if (x6[5:4] == X6_LOOP_GRP) begin
            case (x6[3:0])
                4'd0:    k = KIND_CLOOP;
                4'd1:    k = KIND_CEXIT;
                4'd2:    k = KIND_CTOP;
                4'd3:    k = KIND_WTOP;
                4'd4:    k = KIND_WEXIT;
                default: k = KIND_COND;
            endcase
        end
        return k;
    endfunction

endpackage

// ===== hw/rtl/branch_instruction_decoder.sv =====
// Channel  Direction  Payload (low bit up)
// s_*      in         instruction_bits[40:0], bundle_address[104:41], zero pad
// m_*      out        decode_ok, branch_kind, qualifying_predicate, ... target_address
//
// Two register stages: input register, then result register.
// One instruction per cycle sustained unless m_tready stalls the output; the
// decode and the 64-bit target add sit between the two registers.
// Reset (aresetn low, synchronous) clears both valid flags; payload is not reset.
// A stalled result holds in the output register while the input register
// still takes a new transaction whenever the result register frees up.
module branch_instruction_decoder (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // instruction_bits[40:0], bundle_address[104:41], zero [111:105]
    input  logic [bid_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // decode_ok[0], branch_kind[4:1], qualifying_predicate[10:5],
    // dest_branch_reg[13:11], source_branch_reg[16:14], whether_hint[18:17],
    // dealloc_hint[19], prefetch_hint[20], combined_opcode[28:21],
    // is_indirect[29], target_valid[30], target_address[94:31], zero[95]
    output logic [bid_pkg::M_DATA_W-1:0]   m_tdata
);
    import bid_pkg::*;

    logic               in_valid_reg,  in_valid_next;
    logic [INSTR_W-1:0] instr_reg,     instr_next;
    logic [ADDR_W-1:0]  addr_reg,      addr_next;
    logic               out_valid_reg, out_valid_next;
    bid_result_t        result_reg,    result_next;
    bid_result_t        decoded;
    logic               out_ready;

    bid_decode u_decode (
        .instr  (instr_reg),
        .addr   (addr_reg),
        .result (decoded)
    );

    assign out_ready = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || out_ready;

    always_comb begin
        in_valid_next  = in_valid_reg;
        instr_next     = instr_reg;
        addr_next      = addr_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (out_ready) begin
            out_valid_next = in_valid_reg;
            result_next    = decoded;
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
            instr_next    = s_tdata[INSTR_W-1:0];
            addr_next     = s_tdata[INSTR_W+ADDR_W-1:INSTR_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        instr_reg  <= instr_next;
        addr_reg   <= addr_next;
        result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       result_reg.target_address,
                       result_reg.target_valid,
                       result_reg.is_indirect,
                       result_reg.combined_opcode,
                       result_reg.prefetch_hint,
                       result_reg.dealloc_hint,
                       result_reg.whether_hint,
                       result_reg.source_branch_reg,
                       result_reg.dest_branch_reg,
                       result_reg.qualifying_predicate,
                       result_reg.branch_kind,
                       result_reg.decode_ok};

    a_no_target_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !result_reg.target_valid |-> result_reg.target_address == '0)
        else $error("target address set without a relative target");

    a_invalid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !result_reg.decode_ok |->
            result_reg.branch_kind == KIND_COND && !result_reg.is_indirect &&
            !result_reg.target_valid)
        else $error("invalid major produced a classification");

    a_target_xor_indirect: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(result_reg.is_indirect && result_reg.target_valid))
        else $error("branch both indirect and relative");

    a_pred_forced: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && result_reg.decode_ok &&
        (result_reg.branch_kind == KIND_CLOOP || result_reg.branch_kind == KIND_CTOP ||
         result_reg.branch_kind == KIND_CEXIT || result_reg.branch_kind == KIND_RFI)
        |-> result_reg.qualifying_predicate == 6'd0)
        else $error("predicate not forced for loop or rfi");

    a_stage_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_ready |=> out_valid_reg)
        else $error("decoded transaction lost between stages");

endmodule

// ===== hw/rtl/bid_decode.sv =====
module bid_decode (
    input  logic [bid_pkg::INSTR_W-1:0] instr,
    input  logic [bid_pkg::ADDR_W-1:0]  addr,
    output bid_pkg::bid_result_t        result
);
    import bid_pkg::*;

    logic [3:0]        major;
    logic [2:0]        btype;
    logic [5:0]        x6;
    logic              reg_form;
    logic              ok;
    logic              indirect;
    logic              rel_target;
    bid_kind_e         kind;
    bid_kind_e         rel_kind;
    logic [ADDR_W-1:0] disp;
    logic [ADDR_W-1:0] target_sum;

    assign major = instr[40:37];
    assign btype = instr[8:6];
    assign x6    = instr[32:27];

    // displacement {bit 36, bits 32:13} scaled by a bundle (16 bytes)
    assign disp       = {{(ADDR_W-24){instr[36]}}, instr[32:13], 4'b0000};
    assign target_sum = addr + disp;

    assign reg_form = (major == MAJOR_IND) ||
                      (major == MAJOR_REL && btype == BTYPE_4) ||
                      (major == MAJOR_SYS && btype == BTYPE_4 && x6 != X6_RET_SPEC) ||
                      (major == MAJOR_SYS && x6 == X6_IND_COND);

    always_comb begin
        rel_kind = relative_kind(btype, x6);
        if (major == MAJOR_REL) begin
            case (btype)
                BTYPE_2: rel_kind = KIND_WEXIT;
                BTYPE_3: rel_kind = KIND_WTOP;
                BTYPE_5: rel_kind = KIND_CLOOP;
                BTYPE_6: rel_kind = KIND_CEXIT;
                BTYPE_7: rel_kind = KIND_CTOP;
                default: ;
            endcase
        end
    end

    always_comb begin
        ok         = 1'b1;
        kind       = KIND_COND;
        indirect   = 1'b0;
        rel_target = 1'b0;
        case (major)
            MAJOR_SYS, MAJOR_IND, MAJOR_REL: begin
                if (major == MAJOR_SYS && x6 == X6_RFI) begin
                    kind = KIND_RFI;
                end else if (reg_form) begin
                    indirect = 1'b1;
                    kind = (major == MAJOR_SYS && x6 == X6_IND_COND) ? KIND_COND
                                                                     : register_kind(x6);
                end else if (btype == BTYPE_4 && x6 == X6_RET_SPEC) begin
                    indirect = 1'b1;
                    kind     = KIND_RET;
                end else begin
                    kind       = rel_kind;
                    rel_target = 1'b1;
                end
            end
            MAJOR_CALL: begin
                kind       = (btype == BTYPE_5) ? KIND_CLOOP : KIND_CALL;
                rel_target = 1'b1;
            end
            default: ok = 1'b0;
        endcase
    end

    always_comb begin
        result.decode_ok            = ok;
        result.branch_kind          = kind;
        result.qualifying_predicate = instr[5:0];
        // counted loops and rfi ignore the predicate
        if (ok && (kind == KIND_CLOOP || kind == KIND_CTOP ||
                   kind == KIND_CEXIT || kind == KIND_RFI)) begin
            result.qualifying_predicate = 6'd0;
        end
        result.dest_branch_reg   = instr[8:6];
        result.source_branch_reg = instr[15:13];
        result.whether_hint      = instr[34:33];
        result.dealloc_hint      = instr[35];
        result.prefetch_hint     = instr[12];
        result.combined_opcode   = {major, x6[3:0]};
        result.is_indirect       = indirect;
        result.target_valid      = rel_target;
        result.target_address    = rel_target ? target_sum : '0;
    end

endmodule

// ===== tb/sv/branch_decode_checker.sv =====
module branch_decode_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    // instruction_bits[40:0], bundle_address[104:41], zero [111:105]
    input  logic [bid_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    // decode_ok[0], branch_kind[4:1], qualifying_predicate[10:5],
    // dest_branch_reg[13:11], source_branch_reg[16:14], whether_hint[18:17],
    // dealloc_hint[19], prefetch_hint[20], combined_opcode[28:21],
    // is_indirect[29], target_valid[30], target_address[94:31], zero[95]
    input  logic [bid_pkg::M_DATA_W-1:0] m_tdata,
    output int                           failures,
    output int                           outstanding
);
    import bid_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // x6[4:0] selectors of the register-indirect forms
    localparam logic [4:0] REG_SEL_CALL     = 5'h00;
    localparam logic [4:0] REG_SEL_CALL_ALT = 5'h01;
    localparam logic [4:0] REG_SEL_RET      = 5'h04;
    localparam logic [4:0] REG_SEL_IA       = 5'h05;

    // x6[3:0] selectors inside the loop group
    localparam logic [3:0] LOOP_SEL_CLOOP = 4'd0;
    localparam logic [3:0] LOOP_SEL_CEXIT = 4'd1;
    localparam logic [3:0] LOOP_SEL_CTOP  = 4'd2;
    localparam logic [3:0] LOOP_SEL_WTOP  = 4'd3;
    localparam logic [3:0] LOOP_SEL_WEXIT = 4'd4;

    typedef struct packed {
        logic [INSTR_W-1:0] instr;
        bid_result_t        decoded;
    } decode_entry_t;

    decode_entry_t pending_decodes[$];

    initial begin
        failures    = 0;
        outstanding = 0;
    end

    function automatic bid_result_t decode_branch(input logic [INSTR_W-1:0] bits,
                                                  input logic [ADDR_W-1:0]  addr);
        bid_result_t r;
        logic [3:0]  major;
        logic [5:0]  x6;
        logic [2:0]  btype;
        logic [63:0] disp;
        logic        reg_form;
        major = bits[40:37];
        x6    = bits[32:27];
        btype = bits[8:6];
        // 21-bit displacement {bit 36, bits 32:13} scaled by the bundle size
        disp  = {{40{bits[36]}}, bits[32:13], 4'h0};

        r = '0;
        r.decode_ok            = 1'b1;
        r.branch_kind          = KIND_COND;
        r.qualifying_predicate = bits[5:0];
        r.dest_branch_reg      = bits[8:6];
        r.source_branch_reg    = bits[15:13];
        r.whether_hint         = bits[34:33];
        r.dealloc_hint         = bits[35];
        r.prefetch_hint        = bits[12];
        r.combined_opcode      = {major, x6[3:0]};

        reg_form = (major == MAJOR_IND) ||
                   (major == MAJOR_REL && btype == BTYPE_4) ||
                   (major == MAJOR_SYS && btype == BTYPE_4 && x6 != X6_RET_SPEC) ||
                   (major == MAJOR_SYS && x6 == X6_IND_COND);

        if (major == MAJOR_SYS && x6 == X6_RFI) begin
            r.branch_kind = KIND_RFI;
        end else if (major == MAJOR_SYS || major == MAJOR_IND || major == MAJOR_REL) begin
            if (reg_form) begin
                r.is_indirect = 1'b1;
                if (!(major == MAJOR_SYS && x6 == X6_IND_COND)) begin
                    case (x6[4:0])
                        REG_SEL_CALL, REG_SEL_CALL_ALT: r.branch_kind = KIND_CALL;
                        REG_SEL_RET:                    r.branch_kind = KIND_RET;
                        REG_SEL_IA:                     r.branch_kind = KIND_IA;
                        default:                        r.branch_kind = KIND_COND;
                    endcase
                end
            end else if (btype == BTYPE_4 && x6 == X6_RET_SPEC) begin
                r.is_indirect = 1'b1;
                r.branch_kind = KIND_RET;
            end else begin
                r.target_valid = 1'b1;
                if (btype == BTYPE_1 || btype == BTYPE_5) begin
                    r.branch_kind = KIND_CALL;
                end else if (btype != BTYPE_0 && btype != BTYPE_4 &&
                             x6[5:4] == X6_LOOP_GRP) begin
                    case (x6[3:0])
                        LOOP_SEL_CLOOP: r.branch_kind = KIND_CLOOP;
                        LOOP_SEL_CEXIT: r.branch_kind = KIND_CEXIT;
                        LOOP_SEL_CTOP:  r.branch_kind = KIND_CTOP;
                        LOOP_SEL_WTOP:  r.branch_kind = KIND_WTOP;
                        LOOP_SEL_WEXIT: r.branch_kind = KIND_WEXIT;
                        default:        r.branch_kind = KIND_COND;
                    endcase
                end
                // major 4 picks the loop form from btype alone
                if (major == MAJOR_REL) begin
                    case (btype)
                        BTYPE_2: r.branch_kind = KIND_WEXIT;
                        BTYPE_3: r.branch_kind = KIND_WTOP;
                        BTYPE_5: r.branch_kind = KIND_CLOOP;
                        BTYPE_6: r.branch_kind = KIND_CEXIT;
                        BTYPE_7: r.branch_kind = KIND_CTOP;
                        default: ;
                    endcase
                end
            end
        end else if (major == MAJOR_CALL) begin
            r.branch_kind  = (btype == BTYPE_5) ? KIND_CLOOP : KIND_CALL;
            r.target_valid = 1'b1;
        end else begin
            r.decode_ok = 1'b0;
        end

        if (r.target_valid) begin
            r.target_address = addr + disp;
        end
        if (r.decode_ok && (r.branch_kind == KIND_CLOOP || r.branch_kind == KIND_CTOP ||
                            r.branch_kind == KIND_CEXIT || r.branch_kind == KIND_RFI)) begin
            r.qualifying_predicate = '0;
        end
        return r;
    endfunction

    function automatic bid_result_t unpack_result(input logic [M_DATA_W-1:0] d);
        bid_result_t r;
        r.decode_ok            = d[0];
        r.branch_kind          = bid_kind_e'(d[4:1]);
        r.qualifying_predicate = d[10:5];
        r.dest_branch_reg      = d[13:11];
        r.source_branch_reg    = d[16:14];
        r.whether_hint         = d[18:17];
        r.dealloc_hint         = d[19];
        r.prefetch_hint        = d[20];
        r.combined_opcode      = d[28:21];
        r.is_indirect          = d[29];
        r.target_valid         = d[30];
        r.target_address       = d[94:31];
        return r;
    endfunction

    task automatic note_failure(input string msg);
        failures++;
        if (failures <= REPORT_LIMIT) begin
            $display("%s", msg);
        end
    endtask

    task automatic compare_decode(input decode_entry_t want, input bid_result_t got);
        string       diffs;
        bid_result_t x;
        x     = want.decoded;
        diffs = "";
        if (got.decode_ok !== x.decode_ok) diffs = {diffs, " decode_ok"};
        if (got.branch_kind !== x.branch_kind) diffs = {diffs, " branch_kind"};
        if (got.qualifying_predicate !== x.qualifying_predicate)
            diffs = {diffs, " qualifying_predicate"};
        if (got.dest_branch_reg !== x.dest_branch_reg) diffs = {diffs, " dest_branch_reg"};
        if (got.source_branch_reg !== x.source_branch_reg)
            diffs = {diffs, " source_branch_reg"};
        if (got.whether_hint !== x.whether_hint) diffs = {diffs, " whether_hint"};
        if (got.dealloc_hint !== x.dealloc_hint) diffs = {diffs, " dealloc_hint"};
        if (got.prefetch_hint !== x.prefetch_hint) diffs = {diffs, " prefetch_hint"};
        if (got.combined_opcode !== x.combined_opcode) diffs = {diffs, " combined_opcode"};
        if (got.is_indirect !== x.is_indirect) diffs = {diffs, " is_indirect"};
        if (got.target_valid !== x.target_valid) diffs = {diffs, " target_valid"};
        if (got.target_address !== x.target_address) diffs = {diffs, " target_address"};
        if (diffs != "") begin
            note_failure($sformatf("decode of %h wrong in%s: expected %h, got %h",
                                   want.instr, diffs, x, got));
        end
    endtask

    // Pop before push: a result never leaves in the cycle its instruction enters.
    always @(posedge aclk) begin : monitor
        decode_entry_t head;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (pending_decodes.size() == 0) begin
                    note_failure($sformatf("result %h with no instruction pending", m_tdata));
                end else begin
                    head = pending_decodes.pop_front();
                    compare_decode(head, unpack_result(m_tdata));
                end
            end
            if (s_tvalid && s_tready) begin
                head.instr   = s_tdata[INSTR_W-1:0];
                head.decoded = decode_branch(s_tdata[INSTR_W-1:0],
                                             s_tdata[INSTR_W+ADDR_W-1:INSTR_W]);
                pending_decodes.push_back(head);
            end
        end
        outstanding <= pending_decodes.size();
    end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
    import bid_pkg::*;

    localparam int NUM_RANDOM     = 500;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PAD_W          = S_DATA_W - INSTR_W - ADDR_W;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_TOGGLE
    } rx_pattern_e;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;

    int          failures;
    int          decodes_outstanding;
    int          burst_left  = 0;
    int          idle_cycles = 0;
    int          rx_left     = 0;
    rx_pattern_e rx_pattern  = RX_OPEN;

    initial begin
        forever #6 aclk = ~aclk;
    end

    branch_instruction_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    branch_decode_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (decodes_outstanding)
    );

    function automatic logic [INSTR_W-1:0] random_bits();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[INSTR_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        logic [ADDR_W-1:0] a;
        case ($urandom_range(7))
            0:       a = '0;
            1:       a = '1;
            2:       a = {32'hFFFF_FFFF, $urandom()};
            3:       a = {32'h0, $urandom()};
            default: a = {$urandom(), $urandom()};
        endcase
        return a;
    endfunction

    // Random filler with the classifying fields placed on top.
    function automatic logic [INSTR_W-1:0] form_branch(input logic [3:0] major,
                                                       input logic [5:0] x6,
                                                       input logic [2:0] btype);
        logic [INSTR_W-1:0] b;
        b        = random_bits();
        b[40:37] = major;
        b[32:27] = x6;
        b[8:6]   = btype;
        return b;
    endfunction

    function automatic logic [INSTR_W-1:0] random_branch();
        logic [3:0] major;
        logic [5:0] x6;
        if ($urandom_range(4) == 0) begin
            return random_bits();
        end
        case ($urandom_range(4))
            0:       major = MAJOR_SYS;
            1:       major = MAJOR_IND;
            2:       major = MAJOR_REL;
            3:       major = MAJOR_CALL;
            default: major = 4'($urandom());
        endcase
        case ($urandom_range(6))
            0:       x6 = X6_RFI;
            1:       x6 = X6_IND_COND;
            2:       x6 = X6_RET_SPEC;
            3, 4:    x6 = {X6_LOOP_GRP, 4'($urandom_range(5))};
            default: x6 = 6'($urandom());
        endcase
        return form_branch(major, x6, 3'($urandom()));
    endfunction

    // Called at a falling edge; returns at a falling edge after the transaction.
    task automatic send_item(input logic [INSTR_W-1:0] bits, input logic [ADDR_W-1:0] addr);
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, addr, bits};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(31);
            if ($urandom_range(3) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(negedge aclk);
            end
        end
    endtask

    // Receiver: switch among stall patterns, each held for a random run.
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_pattern = rx_pattern_e'($urandom_range(3));
            rx_left    = $urandom_range(60, 5);
        end else begin
            rx_left--;
        end
        case (rx_pattern)
            RX_OPEN:   m_tready <= 1'b1;
            RX_COIN:   m_tready <= 1'($urandom_range(1));
            RX_SPARSE: m_tready <= ($urandom_range(3) == 0);
            default:   m_tready <= ~m_tready;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [INSTR_W-1:0] b;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: corner fields, every kind, special forms.
        send_item('0, '0);
        send_item('1, '1);
        send_item(form_branch(MAJOR_SYS, X6_RFI, BTYPE_3), random_address());
        send_item(form_branch(MAJOR_SYS, X6_RET_SPEC, BTYPE_4), random_address());
        send_item(form_branch(MAJOR_SYS, X6_IND_COND, BTYPE_1), random_address());
        send_item(form_branch(MAJOR_REL, 6'($urandom()), BTYPE_4), random_address());
        for (int sel = 0; sel < 6; sel++) begin
            send_item(form_branch(MAJOR_IND, 6'(sel), 3'($urandom())), random_address());
        end
        // Loop group under major 0, including an unused low nibble
        for (int sel = 1; sel < 6; sel++) begin
            b = form_branch(MAJOR_SYS, {X6_LOOP_GRP, 4'(sel)}, BTYPE_2);
            if (sel == 5) b[30:27] = 4'($urandom_range(15, 5));
            send_item(b, random_address());
        end
        for (int bt = 2; bt < 8; bt++) begin
            if (bt != 4) begin
                send_item(form_branch(MAJOR_REL, 6'($urandom()), 3'(bt)), random_address());
            end
        end
        // Largest forward displacement across the top of the address space
        b         = form_branch(MAJOR_CALL, '0, BTYPE_0);
        b[36]     = 1'b0;
        b[32:13]  = '1;
        send_item(b, '1);
        // Largest backward displacement below address zero
        b         = form_branch(MAJOR_CALL, '0, BTYPE_5);
        b[36]     = 1'b1;
        b[32:13]  = '0;
        send_item(b, '0);
        send_item(form_branch(4'($urandom_range(3, 2)), 6'($urandom()), 3'($urandom())),
                  random_address());
        send_item(form_branch(4'($urandom_range(15, 6)), 6'($urandom()), 3'($urandom())),
                  random_address());

        repeat (NUM_RANDOM) begin
            send_item(random_branch(), random_address());
        end
        s_tvalid <= 1'b0;

        while (decodes_outstanding != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
